// ===== rtl/conv3x3_sum_normalized_unit_assert.svh =====
// -----------------------------------------------------------------------------
// conv3x3_sum_normalized_unit_assert.svh
// Assertion macros, clocked on clk_i and disabled while rst_ni is low.
// -----------------------------------------------------------------------------
`ifndef CONV3X3_SUM_NORMALIZED_UNIT_ASSERT_SVH
`define CONV3X3_SUM_NORMALIZED_UNIT_ASSERT_SVH

// Same-cycle implication.
`define C3SN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define C3SN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/c3sn_pkg.sv =====
// -----------------------------------------------------------------------------
// c3sn_pkg
// Types and constants of the 3x3 kernel-sum normalized convolution unit.
// -----------------------------------------------------------------------------
package c3sn_pkg;

  localparam int MaxWidth = 1024;
  localparam int ColW     = $clog2(MaxWidth);
  localparam int RowW     = 16;
  localparam int WidthW   = 11;
  localparam int PixW     = 8;
  localparam int CoefW    = 8;
  localparam int NumTaps  = 9;
  localparam int TapIdxW  = $clog2(NumTaps);
  localparam int ProdW    = PixW + 1 + CoefW;
  localparam int AccW     = 20;
  localparam int KsumW    = 12;
  localparam int QuoW     = AccW - 1;
  localparam int DvsW     = KsumW - 1;
  localparam int DivCntW  = $clog2(QuoW);
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;
  localparam int OutDataW = 40;

  localparam logic [CfgIdxW-1:0] CfgCoeffTop = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCoeffMid = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCoeffBot = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgWidth    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgHeight   = 3'd4;

  localparam logic [CfgDataW-1:0] CoeffTopRst = 24'hFFFFFF;
  localparam logic [CfgDataW-1:0] CoeffMidRst = 24'hFF01FF;
  localparam logic [CfgDataW-1:0] CoeffBotRst = 24'hFFFFFF;
  localparam logic [WidthW-1:0]   WidthRst    = 11'd512;
  localparam logic [RowW-1:0]     HeightRst   = 16'd512;

  typedef enum logic [2:0] {
    StIdle,
    StFetch,
    StMac,
    StSetup,
    StDiv,
    StFinish
  } state_e;

endpackage

// ===== rtl/conv3x3_sum_normalized_unit.sv =====
// Flow: fetch, then idle for a border pixel, else multiply-accumulate, setup,
// divide (skipped for a zero kernel sum) and finish, which waits until the
// output is free; a pixel is taken only in idle, paced by the single shared
// multiply-accumulate unit (9 taps) and one-bit-per-cycle divider (19 steps).
// Reset: configuration registers load their defaults, counters clear, line stores
// are not cleared; no clearing pass.
// -----------------------------------------------------------------------------
// conv3x3_sum_normalized_unit
// Streaming 3x3 convolution with two line stores in one synchronous memory,
// result divided by the kernel coefficient sum (undivided when the sum is zero).
// -----------------------------------------------------------------------------
`include "conv3x3_sum_normalized_unit_assert.svh"

module conv3x3_sum_normalized_unit
  import c3sn_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // config write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // pixel input
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [PixW-1:0]     s_axis_tdata,   // [7:0] pixel_in
  input  logic                s_axis_tuser,   // [0] frame_start
  // result output
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [7:0] pixel_out, [23:8] out_row,
                                              // [33:24] out_col, [39:34] zero
  output logic                m_axis_tlast    // frame_last
);

  // configuration
  logic [CfgDataW-1:0] coeff_top_q, coeff_mid_q, coeff_bot_q;
  logic [WidthW-1:0]   width_q;
  logic [RowW-1:0]     height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_top_q <= CoeffTopRst;
      coeff_mid_q <= CoeffMidRst;
      coeff_bot_q <= CoeffBotRst;
      width_q     <= WidthRst;
      height_q    <= HeightRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgCoeffTop: coeff_top_q <= cfg_data_i;
        CfgCoeffMid: coeff_mid_q <= cfg_data_i;
        CfgCoeffBot: coeff_bot_q <= cfg_data_i;
        CfgWidth:    width_q     <= cfg_data_i[WidthW-1:0];
        CfgHeight:   height_q    <= cfg_data_i[RowW-1:0];
        default: ;
      endcase
    end
  end

  // state machine
  state_e state_q, state_d;
  logic   in_xfer, out_load;
  logic   out_valid_q;

  logic [TapIdxW-1:0] tap_idx_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic               produce_q;
  logic signed [KsumW-1:0] ksum_q;

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      StIdle: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_d = StFetch;
      end
      StFetch: state_d = produce_q ? StMac : StIdle;
      StMac: begin
        if (tap_idx_q == TapIdxW'(NumTaps - 1)) state_d = StSetup;
      end
      StSetup: state_d = (ksum_q == '0) ? StFinish : StDiv;
      StDiv: begin
        if (div_cnt_q == DivCntW'(QuoW - 1)) state_d = StFinish;
      end
      StFinish: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_xfer = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  // position of the incoming pixel
  logic [ColW-1:0]   col_q;
  logic [RowW-1:0]   row_q;
  logic [WidthW-1:0] w_eff;
  logic [RowW-1:0]   h_eff;
  logic [ColW-1:0]   col_start, col_acc;
  logic [RowW-1:0]   row_start, row_acc;
  logic [RowW:0]     row_step, row_inc;
  logic [WidthW-1:0] col_inc;
  logic              col_wrap;

  always_comb begin
    if (width_q < WidthW'(3))             w_eff = WidthW'(3);
    else if (width_q > WidthW'(MaxWidth)) w_eff = WidthW'(MaxWidth);
    else                                  w_eff = width_q;
    h_eff     = (height_q < RowW'(3)) ? RowW'(3) : height_q;
    col_start = s_axis_tuser ? '0 : col_q;
    row_start = s_axis_tuser ? '0 : row_q;
    col_wrap  = {1'b0, col_start} >= w_eff;
    row_step  = col_wrap ? ({1'b0, row_start} + 17'd1) : {1'b0, row_start};
    row_acc   = (row_step >= {1'b0, h_eff}) ? '0 : row_step[RowW-1:0];
    col_acc   = col_wrap ? '0 : col_start;
    col_inc   = {1'b0, col_acc} + WidthW'(1);
    row_inc   = {1'b0, row_acc} + 17'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_xfer) begin
      if (col_inc >= w_eff) begin
        col_q <= '0;
        row_q <= (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[RowW-1:0];
      end else begin
        col_q <= col_inc[ColW-1:0];
        row_q <= row_acc;
      end
    end
  end

  // item registers
  logic [PixW-1:0] pix_q;
  logic [ColW-1:0] col_item_q;
  logic [RowW-1:0] orow_q;
  logic [ColW-1:0] ocol_q;
  logic            olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      produce_q <= 1'b0;
    end else if (in_xfer) begin
      produce_q <= (row_acc >= RowW'(2)) && (col_acc >= ColW'(2));
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      pix_q      <= s_axis_tdata;
      col_item_q <= col_acc;
      orow_q     <= row_acc - RowW'(1);
      ocol_q     <= col_acc - ColW'(1);
      olast_q    <= (row_acc == h_eff - RowW'(1)) &&
                    ({1'b0, col_acc} == w_eff - WidthW'(1));
    end
  end

  // line stores: [15:8] two rows above, [7:0] one row above
  logic [2*PixW-1:0] line_mem [MaxWidth];
  logic [2*PixW-1:0] line_rd_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) line_rd_q <= line_mem[col_acc];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StFetch) line_mem[col_item_q] <= {line_rd_q[PixW-1:0], pix_q};
  end

  // window and taps; tap index is row*3 + column
  logic [PixW-1:0] win_q [6];
  logic [PixW-1:0] tap_q [NumTaps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) win_q[i] <= '0;
    end else if (state_q == StFetch) begin
      win_q[0] <= win_q[1];
      win_q[1] <= line_rd_q[2*PixW-1:PixW];
      win_q[2] <= win_q[3];
      win_q[3] <= line_rd_q[PixW-1:0];
      win_q[4] <= win_q[5];
      win_q[5] <= pix_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StFetch) begin
      tap_q[0] <= win_q[0];
      tap_q[1] <= win_q[1];
      tap_q[2] <= line_rd_q[2*PixW-1:PixW];
      tap_q[3] <= win_q[2];
      tap_q[4] <= win_q[3];
      tap_q[5] <= line_rd_q[PixW-1:0];
      tap_q[6] <= win_q[4];
      tap_q[7] <= win_q[5];
      tap_q[8] <= pix_q;
    end
  end

  // multiply-accumulate, one tap per cycle
  logic [3*CfgDataW-1:0]   coeff_all;
  logic signed [CoefW-1:0] coef;
  logic signed [ProdW-1:0] prod;
  logic signed [AccW-1:0]  acc_q;

  assign coeff_all = {coeff_bot_q, coeff_mid_q, coeff_top_q};
  assign coef      = coeff_all[{tap_idx_q, 3'b000} +: CoefW];
  assign prod      = $signed({1'b0, tap_q[tap_idx_q]}) * coef;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_idx_q <= '0;
    end else if (state_q == StMac) begin
      tap_idx_q <= (tap_idx_q == TapIdxW'(NumTaps - 1)) ? '0 : tap_idx_q + TapIdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StFetch) begin
      acc_q  <= '0;
      ksum_q <= '0;
    end else if (state_q == StMac) begin
      acc_q  <= acc_q + {{(AccW-ProdW){prod[ProdW-1]}}, prod};
      ksum_q <= ksum_q + {{(KsumW-CoefW){coef[CoefW-1]}}, coef};
    end
  end

  // restoring divider on magnitudes, one quotient bit per cycle
  logic [AccW-1:0]  acc_abs;
  logic [KsumW-1:0] ksum_abs;
  logic [QuoW-1:0]  quo_q, quo_d;
  logic [DvsW-1:0]  rem_q, rem_d, divisor_q;
  logic [DvsW:0]    trial, trial_sub;
  logic             trial_ge, neg_q;
  logic [PixW-1:0]  res_q;

  always_comb begin
    acc_abs   = acc_q[AccW-1] ? AccW'(-acc_q) : acc_q;
    ksum_abs  = ksum_q[KsumW-1] ? KsumW'(-ksum_q) : ksum_q;
    trial     = {rem_q, quo_q[QuoW-1]};
    trial_ge  = trial >= {1'b0, divisor_q};
    trial_sub = trial - {1'b0, divisor_q};
    rem_d     = trial_ge ? trial_sub[DvsW-1:0] : trial[DvsW-1:0];
    quo_d     = {quo_q[QuoW-2:0], trial_ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (state_q == StSetup) begin
      div_cnt_q <= '0;
    end else if (state_q == StDiv) begin
      div_cnt_q <= div_cnt_q + DivCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StSetup) begin
      quo_q     <= acc_abs[QuoW-1:0];
      rem_q     <= '0;
      divisor_q <= ksum_abs[DvsW-1:0];
      neg_q     <= acc_q[AccW-1] ^ ksum_q[KsumW-1];
      res_q     <= acc_q[PixW-1:0];
    end else if (state_q == StDiv) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
      if (div_cnt_q == DivCntW'(QuoW - 1)) begin
        res_q <= neg_q ? PixW'(-quo_d[PixW-1:0]) : quo_d[PixW-1:0];
      end
    end
  end

  // output register
  logic [OutDataW-1:0] out_data_q;
  logic                out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {{(OutDataW-PixW-RowW-ColW){1'b0}}, ocol_q, orow_q, res_q};
      out_last_q <= olast_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  `C3SN_ASSERT_NEXT(a_xfer_fetch, in_xfer, state_q == StFetch, "transfer in did not start fetch")
  `C3SN_ASSERT_NOW(a_div_nonzero, state_q == StDiv, divisor_q != '0, "divide by zero")
  `C3SN_ASSERT_NOW(a_rem_below, state_q == StDiv, rem_q < divisor_q, "divider remainder too large")
  `C3SN_ASSERT_NOW(a_load_free, out_load, !out_valid_q || m_axis_tready, "result overwritten")

endmodule

// ===== tb/sv/c3sn_result_checker.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// c3sn_result_checker
// Watches the config, pixel and result channels of the 3x3 kernel-sum
// normalized convolution unit. It keeps its own line stores, window and
// position counters, predicts each filtered interior pixel on the pixel
// transfer that completes its window, and compares every result transfer
// field by field with the oldest prediction.
// -----------------------------------------------------------------------------
module c3sn_result_checker
  import c3sn_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [PixW-1:0]     s_axis_tdata,
  input  logic                s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic                m_axis_tlast,
  output int                  error_count,
  output int                  pending_count
);

  localparam int PadLsb = PixW + RowW + ColW;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            last;
  } filtered_px_t;

  logic [CfgDataW-1:0] kernel_rows [3];
  logic [WidthW-1:0]   width_reg;
  logic [RowW-1:0]     height_reg;
  bit   [PixW-1:0]     row_above [MaxWidth];
  bit   [PixW-1:0]     row_above2 [MaxWidth];
  bit   [PixW-1:0]     window [3][2];
  int unsigned         row_pos;
  int unsigned         col_pos;
  filtered_px_t        expected_px_q[$];
  filtered_px_t        want;
  int                  errors;

  task automatic note_error(input string field, input int exp_val, input int act_val);
    errors++;
    if (errors <= 10) begin
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, field, exp_val,
               act_val);
    end
  endtask

  task automatic filter_pixel(input logic [PixW-1:0] pix, input logic frame_start);
    int unsigned  w;
    int unsigned  h;
    int unsigned  r;
    int unsigned  c;
    logic [PixW-1:0] cur [3];
    int           acc;
    int           ksum;
    int           coef;
    int           quo;
    filtered_px_t res;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > MaxWidth) w = MaxWidth;
    h = height_reg;
    if (h < 3) h = 3;
    if (frame_start) begin
      row_pos = 0;
      col_pos = 0;
    end
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    r = row_pos;
    c = col_pos;
    cur[0] = row_above2[c];
    cur[1] = row_above[c];
    cur[2] = pix;
    if (r >= 2 && c >= 2) begin
      acc  = 0;
      ksum = 0;
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          coef = $signed(kernel_rows[k][CoefW*j +: CoefW]);
          ksum += coef;
          acc += coef * int'((j == 2) ? cur[k] : window[k][j]);
        end
      end
      quo = (ksum == 0) ? acc : acc / ksum;
      res.pixel = quo[PixW-1:0];
      res.row   = RowW'(r - 1);
      res.col   = ColW'(c - 1);
      res.last  = (r == h - 1) && (c == w - 1);
      expected_px_q.push_back(res);
    end
    for (int k = 0; k < 3; k++) begin
      window[k][0] = window[k][1];
      window[k][1] = cur[k];
    end
    row_above2[c] = cur[1];
    row_above[c]  = cur[2];
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_rows[0] = CoeffTopRst;
      kernel_rows[1] = CoeffMidRst;
      kernel_rows[2] = CoeffBotRst;
      width_reg      = WidthRst;
      height_reg     = HeightRst;
      row_pos        = 0;
      col_pos        = 0;
      errors         = 0;
      foreach (window[k, j]) window[k][j] = '0;
      expected_px_q.delete();
      error_count   <= 0;
      pending_count <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgCoeffTop: kernel_rows[0] = cfg_data_i;
          CfgCoeffMid: kernel_rows[1] = cfg_data_i;
          CfgCoeffBot: kernel_rows[2] = cfg_data_i;
          CfgWidth:    width_reg = cfg_data_i[WidthW-1:0];
          CfgHeight:   height_reg = cfg_data_i[RowW-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        filter_pixel(s_axis_tdata, s_axis_tuser);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_px_q.size() == 0) begin
          note_error("unexpected result, pixel_out", -1, m_axis_tdata[PixW-1:0]);
        end else begin
          want = expected_px_q.pop_front();
          if (m_axis_tdata[PixW-1:0] !== want.pixel) begin
            note_error("pixel_out", want.pixel, m_axis_tdata[PixW-1:0]);
          end
          if (m_axis_tdata[PixW +: RowW] !== want.row) begin
            note_error("out_row", want.row, m_axis_tdata[PixW +: RowW]);
          end
          if (m_axis_tdata[PixW+RowW +: ColW] !== want.col) begin
            note_error("out_col", want.col, m_axis_tdata[PixW+RowW +: ColW]);
          end
          if (m_axis_tlast !== want.last) begin
            note_error("frame_last", want.last, m_axis_tlast);
          end
          if (m_axis_tdata[OutDataW-1:PadLsb] !== '0) begin
            note_error("tdata padding", 0, m_axis_tdata[OutDataW-1:PadLsb]);
          end
        end
      end
      error_count   <= errors;
      pending_count <= expected_px_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_conv3x3_sum_normalized_unit.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_conv3x3_sum_normalized_unit
// Streams grayscale frames through the 3x3 kernel-sum normalized convolution
// unit under a series of kernel and frame-size settings, with random source
// gaps and sink stalls, and reports the verdict of the result checker.
// -----------------------------------------------------------------------------
module tb_conv3x3_sum_normalized_unit;
  import c3sn_pkg::*;

  localparam int ClkPeriod   = 12;
  localparam int ResetCycles = 10;
  localparam int DrainCycles = 48;
  localparam int HoldCycles  = 400;
  localparam int CycleLimit  = 2_000_000;
  localparam int NumCfgRegs  = int'(CfgHeight) + 1;

  typedef enum int {
    IdleNone,
    IdleSrc,
    IdleSnk,
    IdleBoth
  } idle_mode_e;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [PixW-1:0]     s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  int   src_idle_pct  = 0;
  int   snk_stall_pct = 0;
  int   hold_cycles   = 0;
  logic hold_req      = 1'b0;
  logic hold_ack      = 1'b0;
  int   cycle_cnt     = 0;
  int   error_count;
  int   pending_count;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  conv3x3_sum_normalized_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  c3sn_result_checker result_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack      <= hold_req;
      hold_cycles   <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles   <= hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic send_pixel(input logic [PixW-1:0] pix, input logic frame_start);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= frame_start;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // drop valid, wait for outstanding results, then let the block go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [PixW-1:0] random_pixel();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return PixW'($urandom());
    endcase
  endfunction

  function automatic logic [3*CfgDataW-1:0] random_kernel();
    logic [3*CfgDataW-1:0] k;
    int                    s;
    for (int i = 0; i < NumTaps; i++) k[CoefW*i +: CoefW] = CoefW'($urandom());
    if ($urandom_range(2) == 0) begin
      s = 0;
      for (int i = 0; i < NumTaps - 1; i++) begin
        k[CoefW*i +: CoefW] = CoefW'($urandom_range(31) - 16);
        s += $signed(k[CoefW*i +: CoefW]);
      end
      k[CoefW*(NumTaps-1) +: CoefW] = CoefW'(-s);
    end
    return k;
  endfunction

  task automatic stream_frames(input int w, input int h, input int n_items, input int hold_at);
    int   col;
    int   row;
    logic fs;
    col = 0;
    row = 0;
    for (int i = 0; i < n_items; i++) begin
      if (i == 0) fs = 1'b1;
      else if (row == 0 && col == 0) fs = ($urandom_range(3) == 0);
      else fs = ($urandom_range(99) == 0);
      if (fs) begin
        row = 0;
        col = 0;
      end
      if (i == hold_at) hold_req <= ~hold_req;
      send_pixel(random_pixel(), fs);
      col++;
      if (col >= w) begin
        col = 0;
        row = (row + 1 >= h) ? 0 : row + 1;
      end
    end
  endtask

  task automatic run_setting(input logic [CfgDataW-1:0] top, input logic [CfgDataW-1:0] mid,
                             input logic [CfgDataW-1:0] bot, input logic [WidthW-1:0] w,
                             input logic [RowW-1:0] h, input idle_mode_e mode,
                             input int n_items, input int hold_at);
    int ew;
    int eh;
    settle();
    src_idle_pct  <= (mode == IdleSrc) ? 52 : (mode == IdleBoth) ? 23 : 0;
    snk_stall_pct <= (mode == IdleSnk) ? 52 : (mode == IdleBoth) ? 23 : 0;
    write_reg(CfgIdxW'($urandom_range(2**CfgIdxW - 1, NumCfgRegs)), CfgDataW'($urandom()));
    write_reg(CfgCoeffTop, top);
    write_reg(CfgCoeffMid, mid);
    write_reg(CfgCoeffBot, bot);
    write_reg(CfgWidth, CfgDataW'(w));
    write_reg(CfgHeight, CfgDataW'(h));
    cfg_valid_i <= 1'b0;
    ew = (w < 3) ? 3 : (w > MaxWidth) ? MaxWidth : int'(w);
    eh = (h < 3) ? 3 : int'(h);
    stream_frames(ew, eh, n_items, hold_at);
  endtask

  initial begin
    logic [3*CfgDataW-1:0] kern;
    idle_mode_e            mode;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset kernel, 5x4 frame, then a restart in mid-frame
    write_reg(CfgWidth, CfgDataW'(5));
    write_reg(CfgHeight, CfgDataW'(4));
    cfg_valid_i <= 1'b0;
    for (int i = 0; i < 20; i++) begin
      case (i % 3)
        0:       send_pixel('1, i == 0);
        1:       send_pixel('0, 1'b0);
        default: send_pixel(PixW'(i * 37), 1'b0);
      endcase
    end
    send_pixel('1, 1'b0);
    send_pixel('0, 1'b0);
    send_pixel(8'h80, 1'b1);
    send_pixel(8'h7F, 1'b0);

    run_setting(24'h010101, 24'h010101, 24'h010101, 6, 5, IdleNone, 100, 30);
    run_setting(24'h808080, 24'h808080, 24'h808080, 2, 0, IdleSrc, 100, -1);
    run_setting(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 3, 3, IdleSnk, 80, -1);
    run_setting(24'h00FF00, 24'hFF04FF, 24'h00FF00, 8, 6, IdleBoth, 100, -1);
    run_setting('0, '0, '0, 4, 4, IdleNone, 50, -1);
    kern = random_kernel();
    run_setting(kern[0 +: CfgDataW], kern[CfgDataW +: CfgDataW], kern[2*CfgDataW +: CfgDataW],
                3, 16'hFFFF, IdleSrc, 80, -1);
    for (int p = 0; p < 6; p++) begin
      kern = random_kernel();
      mode = idle_mode_e'(p % 4);
      run_setting(kern[0 +: CfgDataW], kern[CfgDataW +: CfgDataW],
                  kern[2*CfgDataW +: CfgDataW],
                  ($urandom_range(4) == 0) ? WidthW'($urandom_range(2)) :
                                             WidthW'($urandom_range(12, 3)),
                  RowW'($urandom_range(8)), mode, 50, (mode == IdleNone) ? 25 : -1);
    end
    kern = random_kernel();
    run_setting(kern[0 +: CfgDataW], kern[CfgDataW +: CfgDataW], kern[2*CfgDataW +: CfgDataW],
                11'h7FF, 3, IdleBoth, 60, -1);
    kern = random_kernel();
    run_setting(kern[0 +: CfgDataW], kern[CfgDataW +: CfgDataW], kern[2*CfgDataW +: CfgDataW],
                7, 5, IdleNone, 60, -1);

    settle();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/c3sn_pkg.sv
rtl/conv3x3_sum_normalized_unit.sv
tb/sv/c3sn_result_checker.sv
tb/sv/tb_conv3x3_sum_normalized_unit.sv
